/* rtl/core/ftvp_pkg.sv */
package ftvp_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 12;
    localparam int TAG_WIDTH_DEFAULT    = 16;
    localparam int POS_WIDTH            = 16;
    localparam int END_TAG_WIDTH        = 16;

    localparam logic [END_TAG_WIDTH-1:0] END_TAG_RESET = 16'd10;

    localparam logic [7:0] CHAR_PIPE   = 8'h7C;
    localparam logic [7:0] CHAR_SOH    = 8'h01;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_WAIT_TAG   = 3'd0,
        PH_READ_TAG   = 3'd1,
        PH_WAIT_VALUE = 3'd2,
        PH_READ_VALUE = 3'd3,
        PH_ERROR      = 3'd4
    } phase_t;

    function automatic logic is_delim(input logic [7:0] b);
        return (b == CHAR_PIPE) || (b == CHAR_SOH);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

endpackage

/* rtl/core/fix_tag_value_parser.sv */
// fix tag=value parser, one byte per beat
// result: a result beat is presented in the cycle after its byte beat is accepted
// throughput: one byte per cycle, limited by the combinational state update
//   (decimal tag multiply by ten and saturate); result_stall holds the input
// reset: rst_n asynchronous active low; clears phase, tag, length, positions,
//   result_valid, and loads end_tag with 10
module fix_tag_value_parser #(
    parameter int LENGTH_WIDTH = ftvp_pkg::LENGTH_WIDTH_DEFAULT,
    parameter int TAG_WIDTH    = ftvp_pkg::TAG_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               end_tag_we,
    input  logic [ftvp_pkg::END_TAG_WIDTH-1:0] end_tag_wdata,

    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  logic [7:0]                         data_byte,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               field_valid,
    output logic [TAG_WIDTH-1:0]               field_tag,
    output logic [LENGTH_WIDTH-1:0]            field_length,
    output logic [ftvp_pkg::POS_WIDTH-1:0]     field_start,
    output logic                               message_done,
    output logic                               parse_error,
    output logic [2:0]                         parser_phase
);

    localparam int POS_W = ftvp_pkg::POS_WIDTH;
    localparam int ET_W  = ftvp_pkg::END_TAG_WIDTH;
    localparam int CMP_W = (TAG_WIDTH > ET_W) ? TAG_WIDTH : ET_W;
    localparam int MUL_W = TAG_WIDTH + 5;

    localparam logic [TAG_WIDTH-1:0]    TAG_MAX = {TAG_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    ftvp_pkg::phase_t          phase_reg, phase_next;
    logic [TAG_WIDTH-1:0]      tag_reg, tag_next;
    logic [LENGTH_WIDTH-1:0]   len_reg, len_next;
    logic [POS_W-1:0]          start_reg, start_next;
    logic [POS_W-1:0]          pos_reg;
    logic [ET_W-1:0]           end_tag_reg;

    logic                      accept;
    logic                      emit;
    logic                      digit;
    logic                      delim;
    logic [3:0]                digit_val;
    logic [MUL_W-1:0]          tag_times_ten;
    logic                      tag_match;

    assign byte_stall = result_valid && result_stall;
    assign accept     = byte_valid && !byte_stall;

    assign digit     = ftvp_pkg::is_digit(data_byte);
    assign delim     = ftvp_pkg::is_delim(data_byte);
    assign digit_val = 4'(data_byte - ftvp_pkg::CHAR_ZERO);

    // tag * 10 + digit as (tag << 3) + (tag << 1) + digit
    assign tag_times_ten = ({5'd0, tag_reg} << 3) + ({5'd0, tag_reg} << 1)
                         + MUL_W'(digit_val);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            ftvp_pkg::PH_WAIT_TAG:
            begin
                if (digit)
                    phase_next = ftvp_pkg::PH_READ_TAG;
            end
            ftvp_pkg::PH_READ_TAG:
            begin
                priority if (digit)
                    phase_next = ftvp_pkg::PH_READ_TAG;
                else if (data_byte == ftvp_pkg::CHAR_EQUALS)
                    phase_next = ftvp_pkg::PH_WAIT_VALUE;
                else
                    phase_next = ftvp_pkg::PH_ERROR;
            end
            ftvp_pkg::PH_WAIT_VALUE:
            begin
                phase_next = delim ? ftvp_pkg::PH_WAIT_TAG : ftvp_pkg::PH_READ_VALUE;
            end
            ftvp_pkg::PH_READ_VALUE:
            begin
                if (delim)
                    phase_next = ftvp_pkg::PH_WAIT_TAG;
            end
            default:
            begin
                phase_next = ftvp_pkg::PH_ERROR;
            end
        endcase
    end

    // datapath and field record
    always_comb
    begin
        tag_next   = tag_reg;
        len_next   = len_reg;
        start_next = start_reg;
        emit       = 1'b0;
        unique case (phase_reg)
            ftvp_pkg::PH_WAIT_TAG:
            begin
                if (digit)
                    tag_next = TAG_WIDTH'(digit_val);
            end
            ftvp_pkg::PH_READ_TAG:
            begin
                if (digit)
                    tag_next = (tag_times_ten > MUL_W'(TAG_MAX)) ? TAG_MAX
                             : tag_times_ten[TAG_WIDTH-1:0];
            end
            ftvp_pkg::PH_WAIT_VALUE:
            begin
                start_next = pos_reg;
                if (delim)
                begin
                    len_next = '0;
                    emit     = 1'b1;
                end
                else
                begin
                    len_next = LENGTH_WIDTH'(1);
                end
            end
            ftvp_pkg::PH_READ_VALUE:
            begin
                priority if (delim)
                    emit = 1'b1;
                else if (len_reg != LEN_MAX)
                    len_next = len_reg + LENGTH_WIDTH'(1);
                else
                    len_next = LEN_MAX;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign tag_match = (CMP_W'(tag_next) == CMP_W'(end_tag_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ftvp_pkg::PH_WAIT_TAG;
            tag_reg     <= '0;
            len_reg     <= '0;
            start_reg   <= '0;
            pos_reg     <= '0;
            end_tag_reg <= ftvp_pkg::END_TAG_RESET;
        end
        else
        begin
            if (end_tag_we)
                end_tag_reg <= end_tag_wdata;
            if (accept)
            begin
                phase_reg <= phase_next;
                tag_reg   <= tag_next;
                len_reg   <= len_next;
                start_reg <= start_next;
                pos_reg   <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (accept)
            result_valid <= 1'b1;
        else if (!result_stall)
            result_valid <= 1'b0;
    end

    // record fields read zero when no field closes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            field_valid  <= emit;
            field_tag    <= emit ? tag_next : '0;
            field_length <= emit ? len_next : '0;
            field_start  <= emit ? start_next : '0;
            message_done <= emit && tag_match;
            parse_error  <= (phase_next == ftvp_pkg::PH_ERROR);
            parser_phase <= phase_next;
        end
    end

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ftvp_pkg::PH_ERROR |=> phase_reg == ftvp_pkg::PH_ERROR)
        else $error("parser left the error state");

    a_field_returns_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && field_valid |-> parser_phase == ftvp_pkg::PH_WAIT_TAG)
        else $error("closed field without return to wait tag");

    a_done_needs_field: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && message_done |-> field_valid)
        else $error("message end flagged without a field");

    a_position_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("byte position did not advance on an accepted beat");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int TAG_W       = ftvp_pkg::TAG_WIDTH_DEFAULT;
    localparam int LEN_W       = ftvp_pkg::LENGTH_WIDTH_DEFAULT;
    localparam int ET_W        = ftvp_pkg::END_TAG_WIDTH;
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic             closed;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
        logic [15:0]      start;
        logic             done;
        logic             err;
        logic [2:0]       phase;
    } field_rec_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     end_tag_we = 1'b0;
    logic [ET_W-1:0]          end_tag_wdata = '0;
    logic                     byte_valid = 1'b0;
    logic                     byte_stall;
    logic [7:0]               data_byte = 8'h00;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic                     field_valid;
    logic [TAG_W-1:0]         field_tag;
    logic [LEN_W-1:0]         field_length;
    logic [ftvp_pkg::POS_WIDTH-1:0] field_start;
    logic                     message_done;
    logic                     parse_error;
    logic [2:0]               parser_phase;

    // stream and parser mirror
    logic [7:0]               stream_bytes[$];
    field_rec_t               pending_fields[$];
    ftvp_pkg::phase_t         mirror_phase = ftvp_pkg::PH_WAIT_TAG;
    logic [TAG_W-1:0]         mirror_tag = '0;
    logic [LEN_W-1:0]         mirror_length = '0;
    logic [15:0]              mirror_start = '0;
    logic [15:0]              mirror_pos = '0;
    logic [ET_W-1:0]          mirror_end_tag = ftvp_pkg::END_TAG_RESET;

    int                       mismatch_count = 0;
    int                       quiet_cycles = 0;
    int                       hold_left = 0;
    bit                       hold_req = 1'b0;
    bit                       steady = 1'b0;

    fix_tag_value_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .end_tag_we   (end_tag_we),
        .end_tag_wdata(end_tag_wdata),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .field_valid  (field_valid),
        .field_tag    (field_tag),
        .field_length (field_length),
        .field_start  (field_start),
        .message_done (message_done),
        .parse_error  (parse_error),
        .parser_phase (parser_phase)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_numeral(input logic [7:0] b);
        return b >= ftvp_pkg::CHAR_ZERO && b <= ftvp_pkg::CHAR_NINE;
    endfunction

    function automatic bit is_separator(input logic [7:0] b);
        return b == ftvp_pkg::CHAR_PIPE || b == ftvp_pkg::CHAR_SOH;
    endfunction

    // advance the mirror by one byte and queue the record it yields
    task automatic parse_byte(input logic [7:0] b);
        field_rec_t  rec;
        logic [31:0] wide;
        rec = '0;
        case (mirror_phase)
            ftvp_pkg::PH_WAIT_TAG:
            begin
                if (is_numeral(b))
                begin
                    mirror_tag   = TAG_W'(b - ftvp_pkg::CHAR_ZERO);
                    mirror_phase = ftvp_pkg::PH_READ_TAG;
                end
            end
            ftvp_pkg::PH_READ_TAG:
            begin
                if (is_numeral(b))
                begin
                    wide = 32'(mirror_tag) * 32'd10 + 32'(b - ftvp_pkg::CHAR_ZERO);
                    mirror_tag = (wide > 32'hFFFF) ? '1 : wide[TAG_W-1:0];
                end
                else if (b == ftvp_pkg::CHAR_EQUALS)
                begin
                    mirror_phase = ftvp_pkg::PH_WAIT_VALUE;
                end
                else
                begin
                    mirror_phase = ftvp_pkg::PH_ERROR;
                end
            end
            ftvp_pkg::PH_WAIT_VALUE:
            begin
                mirror_start = mirror_pos;
                if (is_separator(b))
                begin
                    mirror_length = '0;
                    rec.closed    = 1'b1;
                    mirror_phase  = ftvp_pkg::PH_WAIT_TAG;
                end
                else
                begin
                    mirror_length = LEN_W'(1);
                    mirror_phase  = ftvp_pkg::PH_READ_VALUE;
                end
            end
            ftvp_pkg::PH_READ_VALUE:
            begin
                if (is_separator(b))
                begin
                    rec.closed   = 1'b1;
                    mirror_phase = ftvp_pkg::PH_WAIT_TAG;
                end
                else if (mirror_length != '1)
                begin
                    mirror_length = mirror_length + 1'b1;
                end
            end
            default:
            begin
                mirror_phase = ftvp_pkg::PH_ERROR;
            end
        endcase
        if (rec.closed)
        begin
            rec.tag    = mirror_tag;
            rec.length = mirror_length;
            rec.start  = mirror_start;
            rec.done   = (mirror_tag == mirror_end_tag);
        end
        mirror_pos = mirror_pos + 1'b1;
        rec.err    = (mirror_phase == ftvp_pkg::PH_ERROR);
        rec.phase  = mirror_phase;
        pending_fields.push_back(rec);
    endtask

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                parse_byte(data_byte);
            if (!byte_valid || !byte_stall)
            begin
                if (stream_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    data_byte  <= stream_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req)
        begin
            result_stall <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            hold_req = 1'b0;
        end
        else
        begin
            result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_check
        field_rec_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_fields.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat expected none got tag %0h phase %0h",
                         $time, field_tag, parser_phase);
            end
            else
            begin
                want = pending_fields.pop_front();
                check_field("field_valid", 32'(want.closed), 32'(field_valid));
                check_field("field_tag", 32'(want.tag), 32'(field_tag));
                check_field("field_length", 32'(want.length), 32'(field_length));
                check_field("field_start", 32'(want.start), 32'(field_start));
                check_field("message_done", 32'(want.done), 32'(message_done));
                check_field("parse_error", 32'(want.err), 32'(parse_error));
                check_field("parser_phase", 32'(want.phase), 32'(parser_phase));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
    endtask

    task automatic push_tag(input logic [63:0] value, input int zeros);
        logic [7:0]  digits[$];
        logic [63:0] rest;
        rest = value;
        repeat (zeros) push_byte(ftvp_pkg::CHAR_ZERO);
        do
        begin
            digits.push_front(ftvp_pkg::CHAR_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (digits[i])
            push_byte(digits[i]);
    endtask

    function automatic logic [7:0] content_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_separator(b));
        return b;
    endfunction

    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_numeral(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_separator();
        return $urandom_range(0, 1) ? ftvp_pkg::CHAR_PIPE : ftvp_pkg::CHAR_SOH;
    endfunction

    task automatic push_field(input logic [63:0] tag, input int zeros, input int vlen);
        push_tag(tag, zeros);
        push_byte(ftvp_pkg::CHAR_EQUALS);
        repeat (vlen) push_byte(content_byte());
        push_byte(pick_separator());
    endtask

    task automatic random_fields(input int count);
        int          r;
        int          vlen;
        logic [63:0] tag;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 12)
                repeat ($urandom_range(1, 3)) push_byte(stray_byte());
            r = $urandom_range(0, 99);
            if (r < 25)
                tag = 64'(mirror_end_tag);
            else if (r < 65)
                tag = 64'($urandom_range(0, 99));
            else if (r < 85)
                tag = 64'($urandom_range(0, 65535));
            else
                tag = 64'd65536 + {$urandom(), $urandom_range(0, 15)};
            r = $urandom_range(0, 99);
            if (r < 15)
                vlen = 0;
            else if (r < 90)
                vlen = $urandom_range(1, 10);
            else
                vlen = $urandom_range(11, 40);
            push_field(tag, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, vlen);
        end
    endtask

    // sampled away from the rising edge so driver and monitor updates have settled
    task automatic wait_drained();
        while (stream_bytes.size() != 0 || byte_valid || pending_fields.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_end_tag(input logic [ET_W-1:0] value);
        @(posedge clk);
        end_tag_we    <= 1'b1;
        end_tag_wdata <= value;
        @(posedge clk);
        end_tag_we     <= 1'b0;
        mirror_end_tag = value;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // stray bytes, empty values, extremes of content, leading zeros
        push_byte(ftvp_pkg::CHAR_PIPE);
        push_byte(ftvp_pkg::CHAR_SOH);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ftvp_pkg::CHAR_EQUALS);
        push_field(10, 0, 0);
        push_tag(0, 0);
        push_byte(ftvp_pkg::CHAR_EQUALS);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(ftvp_pkg::CHAR_EQUALS);
        push_byte(ftvp_pkg::CHAR_SOH);
        push_tag(10, 1);
        push_byte(ftvp_pkg::CHAR_EQUALS);
        push_byte(ftvp_pkg::CHAR_NINE);
        push_byte(ftvp_pkg::CHAR_PIPE);
        push_tag(9, 0);
        push_byte(ftvp_pkg::CHAR_EQUALS);
        push_byte(8'h7D);
        push_byte(ftvp_pkg::CHAR_PIPE);
        wait_drained();

        write_end_tag(16'd0);
        push_field(0, 0, 3);
        push_field(0, 2, 0);
        random_fields(8);
        wait_drained();

        // tag saturation, then a long value with no idling on either side
        write_end_tag(16'hFFFF);
        push_field(65535, 0, 1);
        push_field(65536, 0, 0);
        push_field(6553, 0, 2);
        push_field(64'd99999999999, 0, 1);
        steady = 1'b1;
        push_field(58, 0, 60);
        random_fields(4);
        wait_drained();
        steady = 1'b0;

        // receiver holds off while the sender keeps offering
        write_end_tag(16'($urandom_range(0, 65535)));
        random_fields(4);
        hold_req = 1'b1;
        random_fields(8);
        wait_drained();

        // back to the reset value, then the sticky error state to the end
        write_end_tag(ftvp_pkg::END_TAG_RESET);
        random_fields(3);
        push_tag(64'($urandom_range(0, 999)), 0);
        begin : bad_tag_byte
            logic [7:0] b;
            do
                b = stray_byte();
            while (b == ftvp_pkg::CHAR_EQUALS);
            push_byte(b);
        end
        repeat (30) push_byte(8'($urandom_range(0, 255)));
        push_field(10, 0, 2);
        wait_drained();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
